// ===== rtl/core/fdlf_pkg.sv =====
`default_nettype none

package fdlf_pkg;

    localparam int DELAY_W     = 25;
    localparam int GAIN_W      = 16;
    localparam int FRAC_W      = 8;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = 2;

    typedef logic [DELAY_W-1:0] t_delay;
    typedef logic [GAIN_W-1:0]  t_gain;
    typedef logic [APB_AW-1:0]  t_paddr;
    typedef logic [APB_DW-1:0]  t_pdata;

    localparam logic REG_DELAY = 1'b0;
    localparam logic REG_GAIN  = 1'b1;

    localparam t_delay DELAY_RESET = 25'd256;
    localparam t_gain  GAIN_RESET  = 16'd0;

endpackage

`default_nettype wire

// ===== rtl/core/fractional_delay_line_feedback_top.sv =====
`default_nettype none

// Results pass stages s1 to s3 and the interpolator registers, then wait in a 4-entry queue.
// No input is taken while an item sits in s1; its two buffer reads share the single read port.
// Reset clears the delay buffer in one pass over every entry, with no input accepted.
// A delay write is reduced in quotient, remainder and fix steps, with no input accepted.
// Reset gives a delay of 1.0 sample, dry gain of zero and a write pointer of zero.
module fractional_delay_line_feedback_top #(
    parameter int BUFFER_DEPTH = 65536,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // input_sample, return_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // mixed_out, send_out
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   o_m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  fdlf_pkg::t_paddr                     paddr,
    input  fdlf_pkg::t_pdata                     pwdata,
    output fdlf_pkg::t_pdata                     prdata,
    output logic                                 pready
);
    import fdlf_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int PW  = AW + FRAC_W;
    localparam int TDW = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int CW  = $clog2(OFIFO_DEPTH + 1);
    localparam logic [PW:0]   SPAN = (PW+1)'(BUFFER_DEPTH) << FRAC_W;
    localparam logic [AW-1:0] LAST = AW'(BUFFER_DEPTH - 1);
    localparam logic signed [SB:0] SMX = {2'b00, {(SB-1){1'b1}}};
    localparam logic signed [SB:0] SMN = ~SMX;

    t_delay             r_delay;
    t_gain              r_gain;
    logic               w_cfg_wr;
    logic               w_red_busy;
    logic [PW-1:0]      w_dmod;
    logic               w_clearing;

    logic [AW-1:0]      r_wp;
    logic [PW:0]        w_psum;
    logic [PW-1:0]      w_phase;
    logic [AW-1:0]      w_i1;
    logic [AW-1:0]      w_i2;
    logic signed [SB-1:0] w_x;
    logic signed [SB-1:0] w_ret;
    logic signed [SB:0]   w_xr;
    logic [SB-1:0]      w_wdata;
    logic               w_accept;

    logic               r_s1_valid;
    logic [AW-1:0]      r_s1_i1;
    logic [AW-1:0]      r_s1_i2;
    logic [FRAC_W-1:0]  r_s1_frac;
    logic [SB-1:0]      r_s1_x;
    logic [SB-1:0]      r_s1_wdata;
    logic [AW-1:0]      r_s1_waddr;

    logic               r_s2_valid;
    logic [AW-1:0]      r_s2_i2;
    logic [FRAC_W-1:0]  r_s2_frac;
    logic [SB-1:0]      r_s2_x;
    logic [SB-1:0]      r_s2_wdata;
    logic [AW-1:0]      r_s2_waddr;

    logic               r_s3_valid;
    logic [FRAC_W-1:0]  r_s3_frac;
    logic [SB-1:0]      r_s3_x;
    logic [SB-1:0]      r_s3_a;

    logic [AW-1:0]      w_rd_addr;
    logic [SB-1:0]      w_rd_data;

    logic               w_iv;
    logic signed [SB-1:0] w_mixed;
    logic signed [SB-1:0] w_send;

    logic [2*SB-1:0]    r_fifo [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] r_wptr;
    logic [OFIFO_AW-1:0] r_rptr;
    logic [CW-1:0]      r_fcnt;
    logic [CW-1:0]      r_cnt;
    logic               w_pop;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
            r_gain  <= GAIN_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_DELAY: r_delay <= pwdata[DELAY_W-1:0];
                REG_GAIN:  r_gain  <= pwdata[GAIN_W-1:0];
                default:   r_gain  <= r_gain;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DELAY: prdata = APB_DW'(r_delay);
            REG_GAIN:  prdata = APB_DW'(r_gain);
            default:   prdata = '0;
        endcase
    end

    fdlf_delay_mod #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_delay_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cfg_wr && (paddr[2] == REG_DELAY)),
        .i_delay (pwdata[DELAY_W-1:0]),
        .o_busy  (w_red_busy),
        .o_dmod  (w_dmod)
    );

    always_comb begin
        w_psum  = {1'b0, r_wp, {FRAC_W{1'b0}}} + SPAN - {1'b0, w_dmod};
        w_phase = (w_psum >= SPAN) ? PW'(w_psum - SPAN) : PW'(w_psum);
        w_i1    = w_phase[PW-1:FRAC_W];
        w_i2    = (w_i1 == LAST) ? '0 : w_i1 + 1'b1;
        w_x     = i_s_tdata[SB-1:0];
        w_ret   = i_s_tdata[2*SB-1:SB];
        w_xr    = (SB+1)'(w_x) + (SB+1)'(w_ret);
        if (w_xr > SMX) begin
            w_wdata = SMX[SB-1:0];
        end else if (w_xr < SMN) begin
            w_wdata = SMN[SB-1:0];
        end else begin
            w_wdata = w_xr[SB-1:0];
        end
    end

    assign o_s_tready = !r_s1_valid && !w_clearing && !w_red_busy &&
                        (r_cnt < CW'(OFIFO_DEPTH));
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (w_accept) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_i1    <= w_i1;
            r_s1_i2    <= w_i2;
            r_s1_frac  <= w_phase[FRAC_W-1:0];
            r_s1_x     <= w_x;
            r_s1_wdata <= w_wdata;
            r_s1_waddr <= r_wp;
        end
        if (r_s1_valid) begin
            r_s2_i2    <= r_s1_i2;
            r_s2_frac  <= r_s1_frac;
            r_s2_x     <= r_s1_x;
            r_s2_wdata <= r_s1_wdata;
            r_s2_waddr <= r_s1_waddr;
        end
        if (r_s2_valid) begin
            r_s3_frac <= r_s2_frac;
            r_s3_x    <= r_s2_x;
            r_s3_a    <= w_rd_data;
        end
    end

    // The second read and the write share a cycle; the read still sees the old entry.
    assign w_rd_addr = r_s2_valid ? r_s2_i2 : r_s1_i1;

    fdlf_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (w_rd_addr),
        .o_rd_data  (w_rd_data),
        .i_wr_en    (r_s2_valid),
        .i_wr_addr  (r_s2_waddr),
        .i_wr_data  (r_s2_wdata),
        .o_clearing (w_clearing)
    );

    fdlf_interp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_valid),
        .i_a     (r_s3_a),
        .i_b     (w_rd_data),
        .i_frac  (r_s3_frac),
        .i_x     (r_s3_x),
        .i_gain  (r_gain),
        .o_valid (w_iv),
        .o_mixed (w_mixed),
        .o_send  (w_send)
    );

    assign o_m_tvalid = (r_fcnt != '0);
    assign w_pop      = o_m_tvalid && i_m_tready;
    assign o_m_tdata  = TDW'(r_fifo[r_rptr]);

    always_ff @(posedge i_clk) begin
        if (w_iv) begin
            r_fifo[r_wptr] <= {w_send, w_mixed};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fcnt <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_iv) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_fcnt <= r_fcnt + CW'(w_iv) - CW'(w_pop);
            r_cnt  <= r_cnt + CW'(w_accept) - CW'(w_pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fdlf_delay_mod.sv =====
`default_nettype none

module fdlf_delay_mod #(
    parameter int BUFFER_DEPTH = 65536
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  fdlf_pkg::t_delay                             i_delay,
    output logic                                         o_busy,
    output logic [$clog2(BUFFER_DEPTH)+fdlf_pkg::FRAC_W-1:0] o_dmod
);
    import fdlf_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int PW = AW + FRAC_W;
    localparam int QW = DELAY_W - FRAC_W;
    localparam int MW = DELAY_W + QW;
    localparam int RW = DELAY_W + PW + 1;
    localparam int NW = QW + AW + 1;
    localparam longint SPAN_L = longint'(BUFFER_DEPTH) << FRAC_W;
    localparam logic [RW-1:0] SPAN_E  = RW'(SPAN_L);
    localparam logic [QW-1:0] RECIP   = QW'((longint'(1) << DELAY_W) / SPAN_L);
    localparam logic [NW-1:0] DEPTH_N = NW'(BUFFER_DEPTH);

    localparam logic [1:0] STEP_QUOT = 2'd0;
    localparam logic [1:0] STEP_REM  = 2'd1;
    localparam logic [1:0] STEP_FIX  = 2'd2;

    logic          r_busy;
    logic [1:0]    r_step;
    t_delay        r_d;
    logic [QW-1:0] r_q;
    logic [RW-1:0] r_rem;
    logic [MW-1:0] w_prod;
    logic [NW-1:0] w_qd;

    // The reciprocal underestimates the quotient by at most one, so one
    // compare and subtract finishes the reduction.
    assign w_prod = MW'(r_d) * MW'(RECIP);
    assign w_qd   = NW'(r_q) * DEPTH_N;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_QUOT;
            r_rem  <= RW'(DELAY_RESET);
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_QUOT;
            r_d    <= i_delay;
        end else if (r_busy) begin
            case (r_step)
                STEP_QUOT: begin
                    r_q    <= w_prod[MW-1:DELAY_W];
                    r_step <= STEP_REM;
                end
                STEP_REM: begin
                    r_rem  <= RW'(r_d) - (RW'(w_qd) << FRAC_W);
                    r_step <= STEP_FIX;
                end
                default: begin
                    if (r_rem >= SPAN_E) begin
                        r_rem <= r_rem - SPAN_E;
                    end
                    r_busy <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_dmod = r_rem[PW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/fdlf_store.sv =====
`default_nettype none

module fdlf_store #(
    parameter int BUFFER_DEPTH = 65536,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] i_rd_addr,
    output logic [SAMPLE_BITS-1:0]          o_rd_data,
    input  logic                            i_wr_en,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] i_wr_addr,
    input  logic [SAMPLE_BITS-1:0]          i_wr_data,
    output logic                            o_clearing
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(BUFFER_DEPTH - 1);

    logic [SAMPLE_BITS-1:0] r_mem [BUFFER_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_clr_busy;
    logic [AW-1:0]          r_clr_addr;
    logic                   w_we;
    logic [AW-1:0]          w_wa;
    logic [SAMPLE_BITS-1:0] w_wd;

    always_comb begin
        if (r_clr_busy) begin
            w_we = 1'b1;
            w_wa = r_clr_addr;
            w_wd = '0;
        end else begin
            w_we = i_wr_en;
            w_wa = i_wr_addr;
            w_wd = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr_busy;

endmodule

`default_nettype wire

// ===== rtl/core/fdlf_interp.sv =====
`default_nettype none

module fdlf_interp #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_a,
    input  logic signed [SAMPLE_BITS-1:0] i_b,
    input  logic [fdlf_pkg::FRAC_W-1:0]   i_frac,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  fdlf_pkg::t_gain               i_gain,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_mixed,
    output logic signed [SAMPLE_BITS-1:0] o_send
);
    import fdlf_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam logic signed [SB+3:0] MX = {5'b00000, {(SB-1){1'b1}}};
    localparam logic signed [SB+3:0] MN = ~MX;

    logic [FRAC_W:0]          w_wa;
    logic signed [SB+9:0]     r_pa;
    logic signed [SB+9:0]     r_pb;
    logic signed [SB+16:0]    r_pd;
    logic                     r_va;
    logic signed [SB+10:0]    w_sum;
    logic signed [SB-1:0]     w_send;
    logic signed [SB+17:0]    w_dsum;
    logic signed [SB+2:0]     w_dry;
    logic signed [SB+3:0]     w_mix;
    logic signed [SB-1:0]     w_mixed;
    logic                     r_valid;
    logic signed [SB-1:0]     r_mixed;
    logic signed [SB-1:0]     r_send;

    assign w_wa = (FRAC_W+1)'(9'd256) - {1'b0, i_frac};

    always_ff @(posedge i_clk) begin
        r_pa <= i_a * $signed({1'b0, w_wa});
        r_pb <= i_b * $signed({1'b0, i_frac});
        r_pd <= i_x * $signed({1'b0, i_gain});
    end

    always_comb begin
        w_sum  = (SB+11)'(r_pa) + (SB+11)'(r_pb) + (SB+11)'(128);
        w_send = w_sum[SB+7:8];
        w_dsum = (SB+18)'(r_pd) + (SB+18)'(16384);
        w_dry  = w_dsum[SB+17:15];
        w_mix  = (SB+4)'(w_send) + (SB+4)'(w_dry);
        if (w_mix > MX) begin
            w_mixed = MX[SB-1:0];
        end else if (w_mix < MN) begin
            w_mixed = MN[SB-1:0];
        end else begin
            w_mixed = w_mix[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mixed <= w_mixed;
        r_send  <= w_send;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_va    <= i_valid;
            r_valid <= r_va;
        end
    end

    assign o_valid = r_valid;
    assign o_mixed = r_mixed;
    assign o_send  = r_send;

endmodule

`default_nettype wire
